>>> rtl/assert_macros.svh
// Assertion macros used by pressure_temperature_compensation.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTC_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/ptc_pkg.sv
package ptc_pkg;
    localparam int RawW     = 20;
    localparam int TrimW    = 16;
    localparam int WordW    = 32;
    localparam int CfgIdxW  = 4;
    localparam int NumW     = 64;
    localparam int DenW     = 31;
    localparam int RemW     = DenW - 1;
    localparam int DivSteps = NumW;

    localparam logic [CfgIdxW-1:0] RegTrimT1  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegTrimT2  = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] RegTrimT3  = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] RegTrimP1  = CfgIdxW'(3);
    localparam logic [CfgIdxW-1:0] RegTrimP23 = CfgIdxW'(4);
    localparam logic [CfgIdxW-1:0] RegTrimP45 = CfgIdxW'(5);
    localparam logic [CfgIdxW-1:0] RegTrimP67 = CfgIdxW'(6);
    localparam logic [CfgIdxW-1:0] RegTrimP89 = CfgIdxW'(7);

    localparam logic [32:0] TempOffset = 33'd128000;
    localparam logic [20:0] PressBase  = 21'd1048576;
    localparam logic [11:0] PressScale = 12'd3125;
    localparam logic [63:0] DenBias    = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [WordW-1:0] temp;
        logic             inv;
        logic             neg;
    } t_side;
endpackage

>>> rtl/ptc_if.sv
interface ptc_in_if;
    import ptc_pkg::*;
    logic            valid;
    logic            ready;
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_out_if;
    import ptc_pkg::*;
    logic             valid;
    logic             ready;
    logic [WordW-1:0] temperature_centi;
    logic [WordW-1:0] pressure_q24_8;
    logic             pressure_invalid;
    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output pressure_invalid, input ready);
    modport sink (input valid, input temperature_centi, input pressure_q24_8,
                  input pressure_invalid, output ready);
endinterface

interface ptc_cfg_if;
    import ptc_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [WordW-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/ptc_div.sv
module ptc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [ptc_pkg::NumW-1:0] i_num,
    input  logic [ptc_pkg::DenW-1:0] i_den,
    input  ptc_pkg::t_side        i_side,
    output logic                  o_vld,
    output logic [ptc_pkg::NumW-1:0] o_quo,
    output ptc_pkg::t_side        o_side
);
    import ptc_pkg::*;

    logic [RemW-1:0]     r_rem [DivSteps];
    logic [NumW-1:0]     r_nq  [DivSteps];
    logic [DenW-1:0]     r_den [DivSteps];
    t_side               r_sd  [DivSteps];
    logic [DivSteps-1:0] r_vld;

    genvar g;
    for (g = 0; g < DivSteps; g++) begin : g_step
        logic [RemW-1:0] rem_in;
        logic [NumW-1:0] nq_in;
        logic [DenW-1:0] den_in;
        t_side           sd_in;
        logic [DenW-1:0] trial;
        logic            ge;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
            assign den_in = i_den;
            assign sd_in  = i_side;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign nq_in  = r_nq[g-1];
            assign den_in = r_den[g-1];
            assign sd_in  = r_sd[g-1];
        end

        assign trial = {rem_in, nq_in[NumW-1]};
        assign ge    = (trial >= den_in);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? RemW'(trial - den_in) : trial[RemW-1:0];
                r_nq[g]  <= {nq_in[NumW-2:0], ge};
                r_den[g] <= den_in;
                r_sd[g]  <= sd_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DivSteps-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[DivSteps-1];
    assign o_quo  = r_nq[DivSteps-1];
    assign o_side = r_sd[DivSteps-1];
endmodule

>>> rtl/pressure_temperature_compensation.sv
// Channel  Dir  Payload
// i_in     in   raw_temperature[19:0], raw_pressure[19:0]
// o_out    out  temperature_centi[31:0], pressure_q24_8[31:0], pressure_invalid
// i_cfg    in   index[3:0], data[31:0] (registers 0..7, higher index ignored)
//
// One item per cycle while the output is not held; the divider is a 64-step restoring divider.
// Synchronous active-low reset clears valid bits and trim registers.
// A held output freezes the whole pipeline; nothing is dropped or repeated.
// Configuration writes are taken every cycle.
`include "assert_macros.svh"
module pressure_temperature_compensation (
    input logic       i_clk,
    input logic       i_rst_n,
    ptc_in_if.sink    i_in,
    ptc_out_if.source o_out,
    ptc_cfg_if.sink   i_cfg
);
    import ptc_pkg::*;

    localparam int FrontN = 11;
    localparam int BackN  = 6;
    localparam int ApN    = 7;
    localparam int TpN    = 7;

    logic [TrimW-1:0] r_t1, r_t2, r_t3, r_p1;
    logic [WordW-1:0] r_p23, r_p45, r_p67, r_p89;

    logic signed [TrimW-1:0] p2, p3, p4, p5, p6, p7, p8, p9;
    assign p2 = r_p23[15:0];
    assign p3 = r_p23[31:16];
    assign p4 = r_p45[15:0];
    assign p5 = r_p45[31:16];
    assign p6 = r_p67[15:0];
    assign p7 = r_p67[31:16];
    assign p8 = r_p89[15:0];
    assign p9 = r_p89[31:16];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1  <= '0;
            r_t2  <= '0;
            r_t3  <= '0;
            r_p1  <= '0;
            r_p23 <= '0;
            r_p45 <= '0;
            r_p67 <= '0;
            r_p89 <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                RegTrimT1:  r_t1  <= i_cfg.data[TrimW-1:0];
                RegTrimT2:  r_t2  <= i_cfg.data[TrimW-1:0];
                RegTrimT3:  r_t3  <= i_cfg.data[TrimW-1:0];
                RegTrimP1:  r_p1  <= i_cfg.data[TrimW-1:0];
                RegTrimP23: r_p23 <= i_cfg.data;
                RegTrimP45: r_p45 <= i_cfg.data;
                RegTrimP67: r_p67 <= i_cfg.data;
                RegTrimP89: r_p89 <= i_cfg.data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_vld_out;
    logic [FrontN-1:0] r_vld_f;
    logic [BackN-1:0]  r_vld_b;

    assign adv        = !r_vld_out || o_out.ready;
    assign i_in.ready = adv;

    // stage 1
    logic signed [17:0] n_d1;
    logic signed [16:0] n_d2;
    logic signed [33:0] n_m1, n_sq;
    logic signed [33:0] r1_m1, r1_sq;
    assign n_d1 = $signed({1'b0, i_in.raw_temperature[19:3]} - {1'b0, r_t1, 1'b0});
    assign n_d2 = $signed({1'b0, i_in.raw_temperature[19:4]} - {1'b0, r_t1});
    assign n_m1 = n_d1 * $signed(r_t2);
    assign n_sq = n_d2 * n_d2;

    // stage 2
    logic signed [31:0] n_v1, n_sqs;
    logic signed [35:0] n_m3;
    logic signed [31:0] r2_v1;
    logic signed [35:0] r2_m3;
    assign n_v1  = $signed(r1_m1[31:0]) >>> 11;
    assign n_sqs = $signed(r1_sq[31:0]) >>> 12;
    assign n_m3  = $signed(n_sqs[19:0]) * $signed(r_t3);

    // stage 3
    logic signed [31:0] n_v2, n_fine, r3_fine;
    assign n_v2   = $signed(r2_m3[31:0]) >>> 14;
    assign n_fine = r2_v1 + n_v2;

    // stage 4
    logic [31:0]        n_f5;
    logic signed [31:0] n_temp;
    logic signed [32:0] n_a, r4_a;
    assign n_f5   = r3_fine + {r3_fine[29:0], 2'b00} + 32'd128;
    assign n_temp = $signed(n_f5) >>> 8;
    assign n_a    = $signed({r3_fine[31], r3_fine} - TempOffset);

    // stage 5
    logic signed [65:0] n_aa;
    logic signed [48:0] n_ap5, n_ap2;
    logic [63:0]        r5_aa;
    logic signed [48:0] r5_ap5, r5_ap2;
    assign n_aa  = r4_a * r4_a;
    assign n_ap5 = r4_a * p5;
    assign n_ap2 = r4_a * p2;

    // stage 6
    logic signed [48:0] n_bl, n_cl, r6_bl, r6_cl, r6_ap5, r6_ap2;
    logic [31:0]        n_bh, n_ch, r6_bh, r6_ch;
    assign n_bl = $signed({1'b0, r5_aa[31:0]}) * p6;
    assign n_cl = $signed({1'b0, r5_aa[31:0]}) * p3;
    assign n_bh = r5_aa[63:32] * {{16{p6[15]}}, p6};
    assign n_ch = r5_aa[63:32] * {{16{p3[15]}}, p3};

    // stage 7
    logic [63:0]        n_b, n_c, r7_b, r7_c;
    logic signed [48:0] r7_ap2;
    assign n_b = {{15{r6_bl[48]}}, r6_bl} + {r6_bh, 32'b0} + {r6_ap5[46:0], 17'b0}
               + {{13{p4[15]}}, p4, 35'b0};
    assign n_c = {{15{r6_cl[48]}}, r6_cl} + {r6_ch, 32'b0};

    // stage 8
    logic signed [63:0] n_csh;
    logic [63:0]        n_x, n_n, r8_x, r8_n;
    logic [20:0]        n_p0;
    logic [RawW-1:0]    r_ap [ApN];
    assign n_csh = $signed(r7_c) >>> 8;
    assign n_x   = n_csh + {{3{r7_ap2[48]}}, r7_ap2, 12'b0} + DenBias;
    assign n_p0  = PressBase - {1'b0, r_ap[ApN-1]};
    assign n_n   = {12'b0, n_p0, 31'b0} - r7_b;

    // stage 9
    logic [47:0] r9_xl;
    logic [43:0] r9_nl;
    logic [31:0] r9_xh, r9_nh;

    // stage 10
    logic [63:0]       n_xf, n_nf, r10_n;
    logic [DenW-1:0]   r10_a3;
    assign n_xf = {16'b0, r9_xl} + {r9_xh, 32'b0};
    assign n_nf = {20'b0, r9_nl} + {r9_nh, 32'b0};

    // stage 11
    logic [WordW-1:0]  r_tp [TpN];
    logic [NumW-1:0]   r11_num;
    logic [DenW-1:0]   r11_den;
    t_side             r11_sd, n_sd11;
    assign n_sd11.temp = r_tp[TpN-1];
    assign n_sd11.inv  = (r10_a3 == '0);
    assign n_sd11.neg  = r10_n[63] ^ r10_a3[DenW-1];

    logic            div_vld;
    logic [NumW-1:0] div_quo;
    t_side           div_sd;

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_vld_f[FrontN-1]),
        .i_num   (r11_num),
        .i_den   (r11_den),
        .i_side  (r11_sd),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_sd)
    );

    // stages 12 to 17
    logic [63:0]        n_p, n_c2f, n_c1f;
    logic signed [63:0] n_ps;
    logic [63:0]        r12_p, r12_ps, r13_p, r13_ll, r14_p, r14_sq, r14_c2;
    logic [31:0]        r13_hl, r13_ph, r15_sh;
    logic signed [48:0] r13_pl, r15_sl;
    logic [63:0]        r15_pc, r16_pc, r16_c1, r17_s;
    t_side              r_sd [BackN];
    assign n_p   = div_sd.neg ? (64'd0 - div_quo) : div_quo;
    assign n_ps  = $signed(n_p) >>> 13;
    assign n_c2f = {{15{r13_pl[48]}}, r13_pl} + {r13_ph, 32'b0};
    assign n_c1f = {{15{r15_sl[48]}}, r15_sl} + {r15_sh, 32'b0};

    // output
    logic [31:0] n_press;
    logic [WordW-1:0] r_out_temp, r_out_press;
    logic             r_out_inv;
    assign n_press = r17_s[39:8] + {{12{p7[15]}}, p7, 4'b0};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_m1   <= n_m1;
            r1_sq   <= n_sq;
            r2_v1   <= n_v1;
            r2_m3   <= n_m3;
            r3_fine <= n_fine;
            r4_a    <= n_a;
            r5_aa   <= n_aa[63:0];
            r5_ap5  <= n_ap5;
            r5_ap2  <= n_ap2;
            r6_bl   <= n_bl;
            r6_cl   <= n_cl;
            r6_bh   <= n_bh;
            r6_ch   <= n_ch;
            r6_ap5  <= r5_ap5;
            r6_ap2  <= r5_ap2;
            r7_b    <= n_b;
            r7_c    <= n_c;
            r7_ap2  <= r6_ap2;
            r8_x    <= n_x;
            r8_n    <= n_n;
            r9_xl   <= r8_x[31:0] * r_p1;
            r9_xh   <= r8_x[63:32] * {16'b0, r_p1};
            r9_nl   <= r8_n[31:0] * PressScale;
            r9_nh   <= r8_n[63:32] * {20'b0, PressScale};
            r10_a3  <= n_xf[63:33];
            r10_n   <= n_nf;
            r11_num <= r10_n[63] ? (64'd0 - r10_n) : r10_n;
            r11_den <= r10_a3[DenW-1] ? (DenW'(0) - r10_a3) : r10_a3;
            r11_sd  <= n_sd11;
            r_ap[0] <= i_in.raw_pressure;
            for (int k = 1; k < ApN; k++) begin
                r_ap[k] <= r_ap[k-1];
            end
            r_tp[0] <= n_temp;
            for (int k = 1; k < TpN; k++) begin
                r_tp[k] <= r_tp[k-1];
            end
            r12_p   <= n_p;
            r12_ps  <= n_ps;
            r13_p   <= r12_p;
            r13_ll  <= r12_ps[31:0] * r12_ps[31:0];
            r13_hl  <= r12_ps[63:32] * r12_ps[31:0];
            r13_pl  <= $signed({1'b0, r12_p[31:0]}) * p8;
            r13_ph  <= r12_p[63:32] * {{16{p8[15]}}, p8};
            r14_p   <= r13_p;
            r14_sq  <= r13_ll + {r13_hl[30:0], 33'b0};
            r14_c2  <= $signed(n_c2f) >>> 19;
            r15_sl  <= $signed({1'b0, r14_sq[31:0]}) * p9;
            r15_sh  <= r14_sq[63:32] * {{16{p9[15]}}, p9};
            r15_pc  <= r14_p + r14_c2;
            r16_c1  <= $signed(n_c1f) >>> 25;
            r16_pc  <= r15_pc;
            r17_s   <= r16_pc + r16_c1;
            r_sd[0] <= div_sd;
            for (int k = 1; k < BackN; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_out_temp  <= r_sd[BackN-1].temp;
            r_out_inv   <= r_sd[BackN-1].inv;
            r_out_press <= r_sd[BackN-1].inv ? '0 : n_press;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f   <= '0;
            r_vld_b   <= '0;
            r_vld_out <= 1'b0;
        end else if (adv) begin
            r_vld_f   <= {r_vld_f[FrontN-2:0], i_in.valid};
            r_vld_b   <= {r_vld_b[BackN-2:0], div_vld};
            r_vld_out <= r_vld_b[BackN-1];
        end
    end

    assign o_out.valid             = r_vld_out;
    assign o_out.temperature_centi = r_out_temp;
    assign o_out.pressure_q24_8    = r_out_press;
    assign o_out.pressure_invalid  = r_out_inv;

    `PTC_ASSERT(a_inv_zero, i_clk, i_rst_n, o_out.valid && o_out.pressure_invalid |-> o_out.pressure_q24_8 == '0, "invalid item carries nonzero pressure")
    `PTC_ASSERT_NR(a_rst_clear, i_clk, !i_rst_n |=> !o_out.valid, "output valid after reset")
    `PTC_ASSERT(a_stall_hold, i_clk, i_rst_n, !adv |=> $stable(r_vld_f) && $stable(r_vld_b), "pipeline moved while held")
endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    import ptc_pkg::*;

    logic i_clk;
    logic i_rst_n;

    ptc_in_if  in_ch();
    ptc_out_if out_ch();
    ptc_cfg_if cfg_ch();

    pressure_temperature_compensation u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    typedef struct {
        logic [WordW-1:0] temp;
        logic [WordW-1:0] press;
        logic             inv;
    } t_reading;

    logic [15:0] trim_t1, trim_t2, trim_t3, trim_p1;
    logic [31:0] trim_p23, trim_p45, trim_p67, trim_p89;

    t_reading expected_q[$];
    int       mismatches;
    int       readings_checked;
    int       invalid_seen;
    longint   cycle_count;
    bit       rx_idle_on;

    localparam longint CycleLimit = 2000000;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic logic signed [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic t_reading compensate(input logic [19:0] rt, input logic [19:0] rp);
        t_reading r;
        logic signed [31:0] d1, v1, d2, v2, fine, sq;
        logic signed [63:0] a, b, p, ps, c1, c2, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] num, q;
        logic [63:0] ma, mb;
        d1 = 32'(rt >> 3) - 32'({trim_t1, 1'b0});
        v1 = (d1 * $signed({{16{trim_t2[15]}}, trim_t2})) >>> 11;
        d2 = 32'(rt >> 4) - 32'(trim_t1);
        sq = (d2 * d2) >>> 12;
        v2 = (sq * $signed({{16{trim_t3[15]}}, trim_t3})) >>> 14;
        fine = v1 + v2;
        r.temp = (fine * 5 + 128) >>> 8;
        p2 = sext16(trim_p23[15:0]); p3 = sext16(trim_p23[31:16]);
        p4 = sext16(trim_p45[15:0]); p5 = sext16(trim_p45[31:16]);
        p6 = sext16(trim_p67[15:0]); p7 = sext16(trim_p67[31:16]);
        p8 = sext16(trim_p89[15:0]); p9 = sext16(trim_p89[31:16]);
        a = 64'(fine) - 64'sd128000;
        b = a * a * p6;
        b = b + ((a * p5) <<< 17);
        b = b + (p4 <<< 35);
        a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
        a = ((64'sd1 <<< 47) + a) * $signed({48'd0, trim_p1});
        a = a >>> 33;
        r.press = '0;
        r.inv = 1'b1;
        if (a != 0) begin
            p = 64'sd1048576 - $signed({44'd0, rp});
            num = ((p <<< 31) - b) * 64'sd3125;
            ma = num[63] ? -num : num;
            mb = a[63] ? -a : a;
            q = $signed(ma / mb);
            p = (num[63] != a[63]) ? -q : q;
            ps = p >>> 13;
            c1 = (p9 * ps * ps) >>> 25;
            c2 = (p8 * p) >>> 19;
            p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
            r.inv = 1'b0;
        end
        return r;
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp,
                                input bit gaps);
        int n;
        n = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 17) : 0;
        if (n != 0) begin
            in_ch.valid <= 1'b0;
            idle_cycles(n);
        end
        expected_q.push_back(compensate(rt, rp));
        in_ch.valid           <= 1'b1;
        in_ch.raw_temperature <= rt;
        in_ch.raw_pressure    <= rp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_trim(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            RegTrimT1:  trim_t1 = val[15:0];
            RegTrimT2:  trim_t2 = val[15:0];
            RegTrimT3:  trim_t3 = val[15:0];
            RegTrimP1:  trim_p1 = val[15:0];
            RegTrimP23: trim_p23 = val;
            RegTrimP45: trim_p45 = val;
            RegTrimP67: trim_p67 = val;
            RegTrimP89: trim_p89 = val;
            default: ;
        endcase
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        idle_cycles(100);
    endtask

    task automatic load_trims(input logic [15:0] t1, t2, t3, p1,
                              input logic [31:0] p23, p45, p67, p89);
        write_trim(RegTrimT1, {16'hA5A5, t1});
        write_trim(RegTrimT2, {16'h5A5A, t2});
        write_trim(RegTrimT3, 32'(t3));
        write_trim(RegTrimP1, 32'(p1));
        write_trim(RegTrimP23, p23);
        write_trim(RegTrimP45, p45);
        write_trim(RegTrimP67, p67);
        write_trim(RegTrimP89, p89);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_typical;
        load_trims(16'd27504, 16'd26435, -16'sd1000, 16'd36477,
                   {16'd3024, -16'sd10685}, {-16'sd0, 16'd2855},
                   {16'd15500, -16'sd7}, {16'd6000, -16'sd14600});
    endtask

    task automatic test_reset_trims;
        send_reading(20'd0, 20'd0, 1'b0);
        send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
        send_reading(20'h80000, 20'h7FFFF, 1'b0);
        drain();
    endtask

    task automatic test_typical_extremes;
        load_typical();
        send_reading(20'd519888, 20'd415148, 1'b0);
        send_reading(20'd0, 20'd0, 1'b0);
        send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
        send_reading(20'd0, 20'hFFFFF, 1'b0);
        send_reading(20'hFFFFF, 20'd0, 1'b0);
        send_reading(20'h55555, 20'hAAAAA, 1'b0);
        send_reading(20'hAAAAA, 20'h55555, 1'b0);
        drain();
    endtask

    task automatic test_extreme_trims;
        load_trims(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                   32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        send_reading(20'd0, 20'd0, 1'b0);
        send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
        drain();
        load_trims(16'h0000, 16'h8000, 16'h8000, 16'hFFFF,
                   32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000);
        send_reading(20'd0, 20'hFFFFF, 1'b0);
        send_reading(20'hFFFFF, 20'd0, 1'b0);
        drain();
        // zero denominator with nonzero temperature
        load_trims(16'd27504, 16'd26435, -16'sd1000, 16'd0,
                   32'h1234_5678, 32'h0, 32'h0, 32'h0);
        send_reading(20'd519888, 20'd415148, 1'b0);
        drain();
        // stray register index
        write_trim(4'd8, 32'hFFFF_FFFF);
        write_trim(4'd15, 32'hFFFF_FFFF);
        cfg_ch.valid <= 1'b0;
        send_reading(20'd300000, 20'd300000, 1'b0);
        drain();
    endtask

    task automatic test_random_readings(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                drain();
                if (i % 300 == 0) load_typical();
                else load_trims(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom_range(0, 7) == 0 ? 0 : $urandom),
                                $urandom, $urandom, $urandom, $urandom);
                rx_idle_on = ($urandom_range(0, 1) == 1);
            end
            send_reading(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
                         (i / 50) % 2 == 1);
        end
        drain();
    endtask

    initial begin
        cycle_count  = 0;
        in_ch.valid  = 1'b0;
        in_ch.raw_temperature = '0;
        in_ch.raw_pressure    = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        trim_t1 = '0; trim_t2 = '0; trim_t3 = '0; trim_p1 = '0;
        trim_p23 = '0; trim_p45 = '0; trim_p67 = '0; trim_p89 = '0;
        mismatches = 0;
        readings_checked = 0;
        invalid_seen = 0;
        rx_idle_on = 1'b0;
        i_rst_n = 1'b0;
        idle_cycles(12);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_trims();
        rx_idle_on = 1'b1;
        test_typical_extremes();
        test_extreme_trims();
        test_random_readings(880);
        $display("%0d readings checked across several trim sets, %0d with zero denominator",
                 readings_checked, invalid_seen);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("%0d mismatches, %0d readings missing", mismatches, expected_q.size());
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // output side: stall at random
    initial begin
        int wait_n;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_n = rx_idle_on && $urandom_range(0, 2) != 0 ? $urandom_range(0, 17) : 0;
            if (wait_n != 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_reading exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reading at cycle %0d", cycle_count);
            end else begin
                exp_r = expected_q.pop_front();
                readings_checked++;
                if (exp_r.inv) invalid_seen++;
                if (out_ch.temperature_centi !== exp_r.temp ||
                    out_ch.pressure_q24_8 !== exp_r.press ||
                    out_ch.pressure_invalid !== exp_r.inv) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: temp %h/%h press %h/%h inv %b/%b (exp/act)",
                                 exp_r.temp, out_ch.temperature_centi, exp_r.press,
                                 out_ch.pressure_q24_8, exp_r.inv, out_ch.pressure_invalid);
                end
            end
        end
    end
endmodule
